@@ hdl/first_fit_heap_allocator_unit_defines.svh @@
// Assertion macros shared by the first-fit heap allocator modules.
// Expects clk and arst_n in the scope of each use.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ffha_pkg.sv @@
// Shared types and codes for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int CMD_W  = 2;
	localparam int REQ_W  = 13;
	localparam int ADDR_W = 12;
	localparam int STS_W  = 2;
	localparam int USED_W = 13;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_NO_FIT   = 2'd1;
	localparam logic [STS_W-1:0] STS_BAD_ADDR = 2'd2;
	localparam logic [STS_W-1:0] STS_ZERO     = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_address;
		logic [STS_W-1:0]  status;
		logic [USED_W-1:0] used_bytes;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT,
		OP_HEAPRST,
		OP_CALCQ,
		OP_CALCC,
		OP_HZERO,
		OP_RD,
		OP_ADV,
		OP_TAKE,
		OP_SPLIT,
		OP_AFIX,
		OP_FMARK,
		OP_PMERGE,
		OP_NREAD,
		OP_NMERGE,
		OP_FFIX,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [STS_W-1:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             req_zero;
		logic             no_room;
		logic             h_end;
		logic             fit;
		logic             split;
		logic             hit;
		logic             rd_free;
		logic             has_prev;
		logic             n_in;
		logic             out_free;
	} dp_stat_t;

endpackage

@@ hdl/ffha_datapath.sv @@
// Datapath of the first-fit heap allocator: header memory, walk pointer,
// size rounding, used-byte counter and result register. Uses ffha_pkg.
`timescale 1ns / 1ps

module ffha_datapath #(
	parameter int HEAP_BYTES   = 4096,
	parameter int ALIGN_BYTES  = 4,
	parameter int HEADER_BYTES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ffha_pkg::in_item_t in_item,
	input  ffha_pkg::dp_cmd_t  cmd,
	output ffha_pkg::dp_stat_t stat,
	output logic               out_valid,
	input  logic               out_stall,
	output ffha_pkg::out_item_t out_item
);
	import ffha_pkg::*;

	`include "first_fit_heap_allocator_unit_defines.svh"

	function automatic int tz7(input int v);
		int n;
		n = 0;
		for (int i = 0; i < 7; i++) begin
			if (n == i && ((v >> i) & 1) == 0) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

	localparam int HW    = $clog2(HEAP_BYTES);
	localparam int AW    = (HW + 3 > 15) ? HW + 3 : 15;
	localparam int SW    = HW;
	localparam int UW    = $clog2(HEAP_BYTES + 1);
	localparam int TZA   = tz7(ALIGN_BYTES);
	localparam int TZH   = tz7(HEADER_BYTES);
	localparam int TZP   = tz7(HEAP_BYTES);
	localparam int GL0   = (TZA < TZH) ? TZA : TZH;
	localparam int GL    = (GL0 < TZP) ? GL0 : TZP;
	localparam int IW    = (HW - GL > 0) ? HW - GL : 1;
	localparam int DEPTH = 1 << IW;
	localparam int QW    = 14;
	localparam int RS    = 21;
	localparam longint RM = ((64'd1 << RS) + ALIGN_BYTES - 1) / ALIGN_BYTES;

	localparam logic [AW-1:0] HDR    = AW'(HEADER_BYTES);
	localparam logic [AW-1:0] HEAP_C = AW'(HEAP_BYTES);
	localparam logic [SW-1:0] INIT_SZ = SW'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [QW-1:0] ALM1   = QW'(ALIGN_BYTES - 1);
	localparam logic [21:0]   RM_C   = RM[21:0];
	localparam logic [6:0]    AL7    = 7'(ALIGN_BYTES);

	function automatic logic [IW-1:0] to_idx(input logic [AW-1:0] a);
		return a[GL+IW-1:GL];
	endfunction

	logic [SW-1:0] m_size [DEPTH];
	logic [SW-1:0] m_prev [DEPTH];
	logic          m_free [DEPTH];

	in_item_t      item_q;
	logic [AW-1:0] h_q, p_q, chunk_q, csize_q, res_addr_q;
	logic [QW-1:0] q_q;
	logic [UW-1:0] used_q;
	logic          merged_q;
	logic [SW-1:0] rd_size_q, rd_prev_q;
	logic          rd_free_q;
	logic          out_valid_q;
	out_item_t     out_item_q;

	logic [AW-1:0] rsz, rprev, nxt_h, n_split, rem, n_free, p_calc, pm_size, nm_size;
	logic [AW-1:0] used_ext, rd_addr, wr_addr;
	logic [QW-1:0] t_val;
	logic [35:0]   qprod;
	logic [20:0]   cprod;
	logic          has_prev, fit, split, n_in, out_free;
	logic          rd_en, wr_sz_en, wr_pv_en, wr_fr_en, wr_fr;
	logic [SW-1:0] wr_sz, wr_pv;

	assign rsz      = AW'(rd_size_q);
	assign rprev    = AW'(rd_prev_q);
	assign used_ext = AW'(used_q);
	assign nxt_h    = h_q + HDR + rsz;
	assign n_split  = h_q + HDR + chunk_q;
	assign rem      = rsz - chunk_q;
	assign n_free   = h_q + HDR + csize_q;
	assign p_calc   = h_q - rprev - HDR;
	assign pm_size  = rsz + csize_q + HDR;
	assign nm_size  = csize_q + HDR + rsz;
	assign fit      = rd_free_q && (rsz >= chunk_q);
	assign split    = rem >= HDR;
	assign has_prev = (h_q != '0) && (h_q >= rprev + HDR);
	assign n_in     = n_free < HEAP_C;
	assign out_free = !out_valid_q || !out_stall;

	assign t_val = QW'(item_q.request_size) + ALM1;
	assign qprod = {14'd0, RM_C} * {22'd0, t_val};
	assign cprod = {7'd0, q_q} * {14'd0, AL7};

	assign stat.command  = item_q.command;
	assign stat.req_zero = (item_q.request_size == '0);
	assign stat.no_room  = chunk_q > (HEAP_C - used_ext);
	assign stat.h_end    = h_q >= HEAP_C;
	assign stat.fit      = fit;
	assign stat.split    = split;
	assign stat.hit      = (h_q + HDR) == AW'(item_q.block_address);
	assign stat.rd_free  = rd_free_q;
	assign stat.has_prev = has_prev;
	assign stat.n_in     = n_in;
	assign stat.out_free = out_free;

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = h_q;
		wr_addr  = h_q;
		wr_sz_en = 1'b0;
		wr_pv_en = 1'b0;
		wr_fr_en = 1'b0;
		wr_sz    = chunk_q[SW-1:0];
		wr_pv    = '0;
		wr_fr    = 1'b0;
		case (cmd.op)
			OP_INIT, OP_HEAPRST: begin
				wr_addr  = '0;
				wr_sz_en = 1'b1;
				wr_pv_en = 1'b1;
				wr_fr_en = 1'b1;
				wr_sz    = INIT_SZ;
				wr_fr    = 1'b1;
			end
			OP_RD: begin
				rd_en = 1'b1;
			end
			OP_TAKE: begin
				wr_fr_en = 1'b1;
				wr_sz_en = split;
			end
			OP_SPLIT: begin
				wr_addr  = n_split;
				wr_sz_en = 1'b1;
				wr_pv_en = 1'b1;
				wr_fr_en = 1'b1;
				wr_sz    = SW'(rem - HDR);
				wr_pv    = chunk_q[SW-1:0];
				wr_fr    = 1'b1;
			end
			OP_AFIX: begin
				wr_addr  = nxt_h;
				wr_pv_en = nxt_h < HEAP_C;
				wr_pv    = SW'(rem - HDR);
			end
			OP_FMARK: begin
				wr_fr_en = 1'b1;
				wr_fr    = 1'b1;
				rd_en    = has_prev;
				rd_addr  = p_calc;
			end
			OP_PMERGE: begin
				wr_addr  = p_q;
				wr_sz_en = rd_free_q;
				wr_sz    = SW'(pm_size);
			end
			OP_NREAD: begin
				rd_en   = n_in;
				rd_addr = n_free;
			end
			OP_NMERGE: begin
				wr_sz_en = rd_free_q;
				wr_sz    = SW'(nm_size);
			end
			OP_FFIX: begin
				wr_addr  = n_free;
				wr_pv_en = merged_q && n_in;
				wr_pv    = SW'(csize_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_sz_en) begin
			m_size[to_idx(wr_addr)] <= wr_sz;
		end
		if (wr_pv_en) begin
			m_prev[to_idx(wr_addr)] <= wr_pv;
		end
		if (wr_fr_en) begin
			m_free[to_idx(wr_addr)] <= wr_fr;
		end
		if (rd_en) begin
			rd_size_q <= m_size[to_idx(rd_addr)];
			rd_prev_q <= m_prev[to_idx(rd_addr)];
			rd_free_q <= m_free[to_idx(rd_addr)];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				item_q     <= in_item;
				res_addr_q <= '0;
			end
			OP_CALCQ:  q_q <= qprod[RS +: QW];
			OP_CALCC:  chunk_q <= AW'(cprod);
			OP_HZERO:  h_q <= '0;
			OP_ADV:    h_q <= nxt_h;
			OP_TAKE:   res_addr_q <= h_q + HDR;
			OP_FMARK: begin
				csize_q  <= rsz;
				p_q      <= p_calc;
				merged_q <= 1'b0;
			end
			OP_PMERGE: begin
				if (rd_free_q) begin
					h_q      <= p_q;
					csize_q  <= pm_size;
					merged_q <= 1'b1;
				end
			end
			OP_NMERGE: begin
				if (rd_free_q) begin
					csize_q  <= nm_size;
					merged_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= UW'(HEADER_BYTES);
		end else begin
			case (cmd.op)
				OP_INIT, OP_HEAPRST: used_q <= UW'(HEADER_BYTES);
				OP_TAKE: used_q <= split ? UW'(used_ext + chunk_q + HDR) : UW'(used_ext + rsz);
				OP_FMARK: used_q <= UW'(used_ext - rsz);
				OP_PMERGE, OP_NMERGE: begin
					if (rd_free_q) begin
						used_q <= UW'(used_ext - HDR);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_item_q.payload_address <= ADDR_W'(res_addr_q);
			out_item_q.status          <= cmd.res_status;
			out_item_q.used_bytes      <= USED_W'(used_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`FFHA_ASSERT_NOW(a_used_bound, 1'b1, used_q <= UW'(HEAP_BYTES), "used bytes beyond heap")
	`FFHA_ASSERT_NOW(a_emit_free, cmd.op == OP_EMIT, out_free, "result emitted over full slot")
	`FFHA_ASSERT_NOW(a_rw_apart, rd_en && (wr_sz_en || wr_pv_en || wr_fr_en), to_idx(rd_addr) != to_idx(wr_addr), "header read and write collide")

endmodule

@@ hdl/ffha_ctrl.sv @@
// Controller of the first-fit heap allocator: sequences alloc, free and
// heap reset over the datapath. Uses ffha_pkg.
`timescale 1ns / 1ps

module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ffha_pkg::dp_stat_t stat,
	output ffha_pkg::dp_cmd_t  cmd
);
	import ffha_pkg::*;

	`include "first_fit_heap_allocator_unit_defines.svh"

	typedef enum logic [16:0] {
		S_INIT  = 17'd1 << 0,
		S_IDLE  = 17'd1 << 1,
		S_DISP  = 17'd1 << 2,
		S_AQ    = 17'd1 << 3,
		S_AC    = 17'd1 << 4,
		S_AROOM = 17'd1 << 5,
		S_ARD   = 17'd1 << 6,
		S_AEV   = 17'd1 << 7,
		S_ASPL  = 17'd1 << 8,
		S_AFIX  = 17'd1 << 9,
		S_FRD   = 17'd1 << 10,
		S_FEV   = 17'd1 << 11,
		S_FPREV = 17'd1 << 12,
		S_FNRD  = 17'd1 << 13,
		S_FNEV  = 17'd1 << 14,
		S_FFIX  = 17'd1 << 15,
		S_DONE  = 17'd1 << 16
	} state_t;

	state_t           st_q, st_d;
	logic [STS_W-1:0] sts_q, sts_d;

	assign in_stall = (st_q != S_IDLE);

	always_comb begin
		st_d           = st_q;
		sts_d          = sts_q;
		cmd.op         = OP_NOP;
		cmd.res_status = sts_q;
		unique case (st_q)
			S_INIT: begin
				cmd.op = OP_INIT;
				st_d   = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					sts_d  = STS_OK;
					st_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.command)
					CMD_ALLOC: begin
						if (stat.req_zero) begin
							sts_d = STS_ZERO;
							st_d  = S_DONE;
						end else begin
							st_d = S_AQ;
						end
					end
					CMD_FREE: begin
						cmd.op = OP_HZERO;
						st_d   = S_FRD;
					end
					CMD_RESET: begin
						cmd.op = OP_HEAPRST;
						st_d   = S_DONE;
					end
					default: st_d = S_DONE;
				endcase
			end
			S_AQ: begin
				cmd.op = OP_CALCQ;
				st_d   = S_AC;
			end
			S_AC: begin
				cmd.op = OP_CALCC;
				st_d   = S_AROOM;
			end
			S_AROOM: begin
				if (stat.no_room) begin
					sts_d = STS_NO_FIT;
					st_d  = S_DONE;
				end else begin
					cmd.op = OP_HZERO;
					st_d   = S_ARD;
				end
			end
			S_ARD: begin
				if (stat.h_end) begin
					sts_d = STS_NO_FIT;
					st_d  = S_DONE;
				end else begin
					cmd.op = OP_RD;
					st_d   = S_AEV;
				end
			end
			S_AEV: begin
				if (stat.fit) begin
					cmd.op = OP_TAKE;
					st_d   = stat.split ? S_ASPL : S_DONE;
				end else begin
					cmd.op = OP_ADV;
					st_d   = S_ARD;
				end
			end
			S_ASPL: begin
				cmd.op = OP_SPLIT;
				st_d   = S_AFIX;
			end
			S_AFIX: begin
				cmd.op = OP_AFIX;
				st_d   = S_DONE;
			end
			S_FRD: begin
				if (stat.h_end) begin
					sts_d = STS_BAD_ADDR;
					st_d  = S_DONE;
				end else begin
					cmd.op = OP_RD;
					st_d   = S_FEV;
				end
			end
			S_FEV: begin
				if (stat.hit) begin
					if (stat.rd_free) begin
						sts_d = STS_BAD_ADDR;
						st_d  = S_DONE;
					end else begin
						cmd.op = OP_FMARK;
						st_d   = stat.has_prev ? S_FPREV : S_FNRD;
					end
				end else begin
					cmd.op = OP_ADV;
					st_d   = S_FRD;
				end
			end
			S_FPREV: begin
				cmd.op = OP_PMERGE;
				st_d   = S_FNRD;
			end
			S_FNRD: begin
				if (stat.n_in) begin
					cmd.op = OP_NREAD;
					st_d   = S_FNEV;
				end else begin
					st_d = S_FFIX;
				end
			end
			S_FNEV: begin
				cmd.op = OP_NMERGE;
				st_d   = S_FFIX;
			end
			S_FFIX: begin
				cmd.op = OP_FFIX;
				st_d   = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op = OP_EMIT;
					st_d   = S_IDLE;
				end
			end
			default: st_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_INIT;
			sts_q <= STS_OK;
		end else begin
			st_q  <= st_d;
			sts_q <= sts_d;
		end
	end

	`FFHA_ASSERT_NOW(a_walk_in_heap, (st_q == S_ARD || st_q == S_FRD) && cmd.op == OP_RD, !stat.h_end, "header read past heap end")
	`FFHA_ASSERT_NEXT(a_done_to_idle, st_q == S_DONE && stat.out_free, st_q == S_IDLE, "no return to idle after result")
	`FFHA_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(st_q), "state not one-hot")

endmodule

@@ hdl/first_fit_heap_allocator_unit.sv @@
// Top level of the first-fit heap allocator with boundary-tag coalescing.
// Joins ffha_ctrl and ffha_datapath; uses ffha_pkg.
//
//  channel | valid      | stall      | item
//  req     | req_valid  | req_stall  | req_item (command, request_size, block_address)
//  rsp     | rsp_valid  | rsp_stall  | rsp_item (payload_address, status, used_bytes)
//
// One item at a time; the walk reads one block header per read and evaluate
// state pair from the header memory. Alloc rounds the size, checks room and
// walks, then splits if needed. Free walks, marks, then merges with neighbours.
// After reset the init state sets up the heap before req is taken.
// A waiting result in the rsp register does not block the next req.
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit #(
	parameter int HEAP_BYTES   = 4096,
	parameter int ALIGN_BYTES  = 4,
	parameter int HEADER_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ffha_pkg::in_item_t  req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ffha_pkg::out_item_t rsp_item
);
	import ffha_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req_valid),
		.in_stall (req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffha_datapath #(
		.HEAP_BYTES   (HEAP_BYTES),
		.ALIGN_BYTES  (ALIGN_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (req_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (rsp_valid),
		.out_stall (rsp_stall),
		.out_item  (rsp_item)
	);

endmodule
